// File: hw/rtl/mdr_pkg.sv
// Shared types and constants of the modular domain reducer.
package mdr_pkg;

	localparam int ITER_W     = 16;
	localparam int THR_W      = 26;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 26;

	localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NORM_THR = 1'd1;

	localparam logic [ITER_W-1:0] MAX_ITER_RST = 16'd10000;
	localparam logic [THR_W-1:0]  NORM_THR_RST = 26'd16777199;

	typedef enum logic [2:0] {
		UOP_HOLD,
		UOP_LOAD_MUL,
		UOP_MUL,
		UOP_LOAD_DIV,
		UOP_DIV
	} unit_op_t;

	typedef struct packed {
		unit_op_t op;
		logic     clr_acc;
	} unit_cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ROUND,
		ST_SQ_X,
		ST_LD_Y,
		ST_SQ_Y,
		ST_CHECK,
		ST_DIV_X,
		ST_SWAP,
		ST_DIV_Y,
		ST_STORE,
		ST_FINISH
	} state_t;

endpackage

// File: hw/rtl/mdr_ifs.sv
// Point and result channel interfaces of the modular domain reducer.
interface mdr_point_if #(parameter int WORD_BITS = 48);
	logic                        valid;
	logic                        ready;
	logic signed [WORD_BITS-1:0] x_in;
	logic        [WORD_BITS-2:0] y_in;

	modport source(output valid, output x_in, output y_in, input ready);
	modport sink(input valid, input x_in, input y_in, output ready);
endinterface

interface mdr_result_if #(parameter int WORD_BITS = 48);
	logic                             valid;
	logic                             ready;
	logic signed [WORD_BITS-1:0]      x_out;
	logic        [WORD_BITS-2:0]      y_out;
	logic        [mdr_pkg::ITER_W-1:0] rounds_used;
	logic                             cap_reached;

	modport source(output valid, output x_out, output y_out, output rounds_used,
		output cap_reached, input ready);
	modport sink(input valid, input x_out, input y_out, input rounds_used,
		input cap_reached, output ready);
endinterface

// File: hw/rtl/mdr_unit.sv
// Shared bit-serial unit: shift-add square accumulation and restoring division.
module mdr_unit #(
	parameter int WORD_BITS = 48,
	parameter int FRAC_BITS = 24
) (
	input  logic                          clk,
	input  mdr_pkg::unit_cmd_t            cmd,
	input  logic [((FRAC_BITS > WORD_BITS - 1) ? FRAC_BITS : WORD_BITS - 1)-1:0] operand,
	input  logic [mdr_pkg::THR_W-1:0]     divisor,
	output logic [2*WORD_BITS-1:0]        acc,
	output logic [WORD_BITS-2:0]          quot
);
	localparam int QW  = WORD_BITS - 1;
	localparam int OPW = (FRAC_BITS > QW) ? FRAC_BITS : QW;
	localparam int AW  = 2 * WORD_BITS;
	localparam int NW  = mdr_pkg::THR_W;

	logic [AW-1:0]  acc_q;
	logic [AW-1:0]  mcand_q;
	logic [OPW-1:0] mplier_q;
	logic           ovf_q;

	logic [NW:0]    rem_sh;
	logic [AW-1:0]  add_a;
	logic [AW-1:0]  add_b;
	logic           cin;
	logic [AW:0]    sum;
	logic           ge;

	// Division: shift the next dividend bit into the remainder, then trial-subtract.
	assign rem_sh = {acc_q[NW-1:0], mcand_q[OPW-1]};

	always_comb begin
		if (cmd.op == mdr_pkg::UOP_MUL) begin
			add_a = acc_q;
			add_b = mplier_q[0] ? mcand_q : '0;
			cin   = 1'b0;
		end else begin
			add_a = AW'(rem_sh);
			add_b = ~AW'(divisor);
			cin   = 1'b1;
		end
	end

	assign sum = {1'b0, add_a} + {1'b0, add_b} + (AW+1)'(cin);
	assign ge  = sum[AW];

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			mdr_pkg::UOP_HOLD: begin
			end
			mdr_pkg::UOP_LOAD_MUL: begin
				if (cmd.clr_acc) begin
					acc_q <= '0;
				end
				mcand_q  <= AW'(operand);
				mplier_q <= operand;
			end
			mdr_pkg::UOP_MUL: begin
				acc_q    <= sum[AW-1:0];
				mcand_q  <= mcand_q << 1;
				mplier_q <= mplier_q >> 1;
			end
			mdr_pkg::UOP_LOAD_DIV: begin
				acc_q    <= '0;
				mcand_q  <= AW'(operand);
				mplier_q <= '0;
				ovf_q    <= 1'b0;
			end
			mdr_pkg::UOP_DIV: begin
				acc_q    <= ge ? sum[AW-1:0] : AW'(rem_sh);
				mcand_q  <= mcand_q << 1;
				mplier_q <= OPW'({mplier_q[QW-2:0], ge});
				// a quotient bit leaving the top of the word means saturation
				ovf_q    <= ovf_q | mplier_q[QW-1];
			end
		endcase
	end

	assign acc  = acc_q;
	assign quot = ovf_q ? {QW{1'b1}} : mplier_q[QW-1:0];

endmodule

// File: hw/rtl/modular_domain_reducer.sv
// Top level of the modular domain reducer: sequencer, item registers, result register.
//
// Folds a point x + iy (signed fixed point, FRAC_BITS fraction bits) into the
// fundamental domain of the modular group: translate x to [-1/2, 1/2], stop once
// x^2 + y^2 reaches norm_threshold, else invert to (-x/n, y/n) and repeat, at most
// max_iterations times. One point is worked at a time; point.ready is high only in
// idle. All arithmetic runs on one bit-serial shared unit, one multiplier bit or
// one quotient bit per cycle. An inversion round squares the translated x, then
// adds y^2 on top, forms the two quotients of x and y by the truncated norm, and
// steps through the ROUND, LD_Y, CHECK, SWAP and STORE sequencing states. A point
// runs its inversion rounds, then a final threshold round (or only the cap check
// when the cap runs out), and then hands the result to the output register.
// That register holds a result until it is taken while the next point is
// already accepted.
module modular_domain_reducer #(
	parameter int WORD_BITS = 48,
	parameter int FRAC_BITS = 24
) (
	input  logic                              clk,
	input  logic                              arst_n,
	mdr_point_if.sink                         point,
	mdr_result_if.source                      result,
	input  logic                              cfg_wr_en,
	input  logic [mdr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mdr_pkg::CFG_DATA_W-1:0]    cfg_data
);
	localparam int W         = WORD_BITS;
	localparam int F         = FRAC_BITS;
	localparam int QW        = W - 1;
	localparam int OPW       = (F > QW) ? F : QW;
	localparam int AW        = 2 * W;
	localparam int NW        = mdr_pkg::THR_W;
	localparam int IW        = mdr_pkg::ITER_W;
	localparam int DIV_STEPS = OPW + F;
	localparam int CNT_W     = $clog2(DIV_STEPS + 1);
	localparam logic [F-1:0] HALF    = {1'b1, {(F-1){1'b0}}};
	localparam logic [F-1:0] ONE_LSB = {{(F-1){1'b0}}, 1'b1};

	mdr_pkg::state_t state_q, state_d;

	// configuration
	logic [IW-1:0] max_it_q;
	logic [NW-1:0] thr_q;

	// item working registers
	logic [W-1:0]     x_q;
	logic [QW-1:0]    y_q;
	logic [IW-1:0]    rounds_q;
	logic             cap_q;
	logic [NW-1:0]    n_q;
	logic [CNT_W-1:0] cnt_q;

	// result register
	logic          out_valid_q;
	logic [W-1:0]  x_out_q;
	logic [QW-1:0] y_out_q;
	logic [IW-1:0] rounds_out_q;
	logic          cap_out_q;

	// shared unit
	mdr_pkg::unit_cmd_t ucmd;
	logic [OPW-1:0]     uoperand;
	logic [AW-1:0]      norm;
	logic [QW-1:0]      quot;

	// datapath terms
	logic [F-1:0]  frac;
	logic          neg_sel;
	logic [W-1:0]  x_trans;
	logic [F-1:0]  ax_trans;
	logic [F-1:0]  ax_cur;
	logic          stop;
	logic [NW-1:0] n_raw;
	logic [NW-1:0] n_next;
	logic [W-1:0]  x_div;
	logic          last_step;
	logic          cap_hit;
	logic          out_free;

	// sequencer strobes
	logic             ld_item;
	logic             wr_xt;
	logic             wr_n;
	logic             wr_xd;
	logic             wr_y;
	logic             set_cap;
	logic             clr_cap;
	logic             out_wr;
	logic             cnt_ld;
	logic             cnt_dec;
	logic [CNT_W-1:0] cnt_val;

	mdr_unit #(
		.WORD_BITS(W),
		.FRAC_BITS(F)
	) u_unit (
		.clk     (clk),
		.cmd     (ucmd),
		.operand (uoperand),
		.divisor (n_q),
		.acc     (norm),
		.quot    (quot)
	);

	// Translate by round-half-away-from-zero: keep the fraction, go negative when
	// it exceeds one half, and on an exact half flip to the opposite sign.
	assign frac     = x_q[F-1:0];
	assign neg_sel  = (frac > HALF) || ((frac == HALF) && !x_q[W-1]);
	assign x_trans  = {{(W-F){neg_sel}}, frac};
	assign ax_trans = neg_sel ? (~frac + ONE_LSB) : frac;
	// magnitude of an already translated x
	assign ax_cur   = x_q[W-1] ? (~x_q[F-1:0] + ONE_LSB) : x_q[F-1:0];

	assign stop      = norm >= (AW'(thr_q) << F);
	assign n_raw     = norm[F +: NW];
	assign n_next    = (n_raw == '0) ? NW'(1) : n_raw;
	// the new x takes the sign opposite to the translated x
	assign x_div     = x_q[W-1] ? {1'b0, quot} : (W'(0) - {1'b0, quot});
	assign last_step = (cnt_q == CNT_W'(1));
	assign cap_hit   = (rounds_q == max_it_q);
	assign out_free  = !out_valid_q || result.ready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mdr_pkg::ST_IDLE:   if (point.valid) state_d = mdr_pkg::ST_ROUND;
			mdr_pkg::ST_ROUND:  state_d = cap_hit ? mdr_pkg::ST_FINISH : mdr_pkg::ST_SQ_X;
			mdr_pkg::ST_SQ_X:   if (last_step) state_d = mdr_pkg::ST_LD_Y;
			mdr_pkg::ST_LD_Y:   state_d = mdr_pkg::ST_SQ_Y;
			mdr_pkg::ST_SQ_Y:   if (last_step) state_d = mdr_pkg::ST_CHECK;
			mdr_pkg::ST_CHECK:  state_d = stop ? mdr_pkg::ST_FINISH : mdr_pkg::ST_DIV_X;
			mdr_pkg::ST_DIV_X:  if (last_step) state_d = mdr_pkg::ST_SWAP;
			mdr_pkg::ST_SWAP:   state_d = mdr_pkg::ST_DIV_Y;
			mdr_pkg::ST_DIV_Y:  if (last_step) state_d = mdr_pkg::ST_STORE;
			mdr_pkg::ST_STORE:  state_d = mdr_pkg::ST_ROUND;
			mdr_pkg::ST_FINISH: if (out_free) state_d = mdr_pkg::ST_IDLE;
			default:            state_d = mdr_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		point.ready  = 1'b0;
		ucmd.op      = mdr_pkg::UOP_HOLD;
		ucmd.clr_acc = 1'b0;
		uoperand     = '0;
		ld_item      = 1'b0;
		wr_xt        = 1'b0;
		wr_n         = 1'b0;
		wr_xd        = 1'b0;
		wr_y         = 1'b0;
		set_cap      = 1'b0;
		clr_cap      = 1'b0;
		out_wr       = 1'b0;
		cnt_ld       = 1'b0;
		cnt_dec      = 1'b0;
		cnt_val      = '0;
		unique case (state_q)
			mdr_pkg::ST_IDLE: begin
				point.ready = 1'b1;
				ld_item     = point.valid;
			end
			mdr_pkg::ST_ROUND: begin
				if (cap_hit) begin
					set_cap = 1'b1;
				end else begin
					wr_xt        = 1'b1;
					ucmd.op      = mdr_pkg::UOP_LOAD_MUL;
					ucmd.clr_acc = 1'b1;
					uoperand     = OPW'(ax_trans);
					cnt_ld       = 1'b1;
					cnt_val      = CNT_W'(F);
				end
			end
			mdr_pkg::ST_SQ_X, mdr_pkg::ST_SQ_Y: begin
				ucmd.op = mdr_pkg::UOP_MUL;
				cnt_dec = 1'b1;
			end
			mdr_pkg::ST_LD_Y: begin
				// keep x^2 in the accumulator and add y^2 on top
				ucmd.op  = mdr_pkg::UOP_LOAD_MUL;
				uoperand = OPW'(y_q);
				cnt_ld   = 1'b1;
				cnt_val  = CNT_W'(QW);
			end
			mdr_pkg::ST_CHECK: begin
				if (stop) begin
					clr_cap = 1'b1;
				end else begin
					wr_n     = 1'b1;
					ucmd.op  = mdr_pkg::UOP_LOAD_DIV;
					uoperand = OPW'(ax_cur);
					cnt_ld   = 1'b1;
					cnt_val  = CNT_W'(DIV_STEPS);
				end
			end
			mdr_pkg::ST_DIV_X, mdr_pkg::ST_DIV_Y: begin
				ucmd.op = mdr_pkg::UOP_DIV;
				cnt_dec = 1'b1;
			end
			mdr_pkg::ST_SWAP: begin
				wr_xd    = 1'b1;
				ucmd.op  = mdr_pkg::UOP_LOAD_DIV;
				uoperand = OPW'(y_q);
				cnt_ld   = 1'b1;
				cnt_val  = CNT_W'(DIV_STEPS);
			end
			mdr_pkg::ST_STORE: begin
				wr_y = 1'b1;
			end
			mdr_pkg::ST_FINISH: begin
				out_wr = out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mdr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_it_q <= mdr_pkg::MAX_ITER_RST;
			thr_q    <= mdr_pkg::NORM_THR_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				mdr_pkg::REG_MAX_ITER: max_it_q <= cfg_data[IW-1:0];
				mdr_pkg::REG_NORM_THR: thr_q    <= cfg_data[NW-1:0];
			endcase
		end
	end

	// control registers of the item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rounds_q <= '0;
			cap_q    <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (ld_item) begin
				rounds_q <= '0;
			end else if (wr_y) begin
				rounds_q <= rounds_q + IW'(1);
			end
			if (set_cap) begin
				cap_q <= 1'b1;
			end else if (clr_cap) begin
				cap_q <= 1'b0;
			end
			if (cnt_ld) begin
				cnt_q <= cnt_val;
			end else if (cnt_dec) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	// point payload
	always_ff @(posedge clk) begin
		if (ld_item) begin
			x_q <= point.x_in;
			y_q <= point.y_in;
		end else begin
			if (wr_xt) begin
				x_q <= x_trans;
			end else if (wr_xd) begin
				x_q <= x_div;
			end
			if (wr_y) begin
				y_q <= quot;
			end
		end
		if (wr_n) begin
			n_q <= n_next;
		end
	end

	// result register: hold until taken, refill only when free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_wr) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_wr) begin
			x_out_q      <= x_q;
			y_out_q      <= y_q;
			rounds_out_q <= rounds_q;
			cap_out_q    <= cap_q;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.x_out       = x_out_q;
	assign result.y_out       = y_out_q;
	assign result.rounds_used = rounds_out_q;
	assign result.cap_reached = cap_out_q;

`ifndef SYNTH
	a_accept_starts_round: assert property (@(posedge clk) disable iff (!arst_n)
		(point.valid && point.ready) |=> (state_q == mdr_pkg::ST_ROUND))
		else $error("accepted transaction did not start a round");

	a_step_count_live: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == mdr_pkg::ST_SQ_X) || (state_q == mdr_pkg::ST_SQ_Y) ||
		 (state_q == mdr_pkg::ST_DIV_X) || (state_q == mdr_pkg::ST_DIV_Y))
		|-> (cnt_q != '0))
		else $error("step counter ran out inside a serial phase");

	a_divisor_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == mdr_pkg::ST_DIV_X) || (state_q == mdr_pkg::ST_DIV_Y))
		|-> (n_q != '0))
		else $error("division by a zero norm");

	a_result_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == mdr_pkg::ST_FINISH))
		else $error("result raised outside the finish step");
`endif

endmodule

// File: tb/sv/tb_modular_domain_reducer.sv
// Testbench of the modular domain reducer: random and directed points checked against a predictor.
module tb_modular_domain_reducer;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WB = 48;
	localparam int FB = 24;

	// Cycle budget of one inversion round and of the closing threshold round.
	localparam longint ROUND_CYCLES = 3 * WB + 3 * FB + 2;
	localparam longint CLOSE_CYCLES = WB + FB + 4;
	localparam int     HOLD_CYCLES  = 600;
	localparam int     SETTLE_CYCLES = 40;

	localparam logic signed [WB-1:0] ONE_FX  = 48'sd1 <<< FB;
	localparam logic signed [WB-1:0] HALF_FX = 48'sd1 <<< (FB - 1);
	localparam logic signed [WB-1:0] X_MAX   = {1'b0, {(WB-1){1'b1}}};
	localparam logic signed [WB-1:0] X_MIN   = {1'b1, {(WB-1){1'b0}}};
	localparam logic [WB-2:0]        Y_ONE   = 47'd1 << FB;
	localparam logic [WB-2:0]        Y_MAX   = {(WB-1){1'b1}};
	localparam logic [mdr_pkg::THR_W-1:0] THR_TOP = {mdr_pkg::THR_W{1'b1}};
	localparam logic [mdr_pkg::THR_W-1:0] THR_TWO = 26'd33554432;

	typedef struct packed {
		logic signed [WB-1:0]       x;
		logic [WB-2:0]              y;
		logic [mdr_pkg::ITER_W-1:0] rounds;
		logic                       cap_hit;
	} fold_t;

	typedef enum logic [1:0] {
		STIM_POINT,
		STIM_CFG,
		STIM_DRAIN,
		STIM_HOLD
	} stim_kind_t;

	typedef struct {
		stim_kind_t                     kind;
		logic signed [WB-1:0]           x;
		logic [WB-2:0]                  y;
		bit                             calm;
		logic [mdr_pkg::CFG_IDX_W-1:0]  reg_idx;
		logic [mdr_pkg::CFG_DATA_W-1:0] reg_val;
	} stim_t;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [mdr_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [mdr_pkg::CFG_DATA_W-1:0] cfg_data;

	mdr_point_if  #(.WORD_BITS(WB)) point_ch();
	mdr_result_if #(.WORD_BITS(WB)) result_ch();

	modular_domain_reducer #(
		.WORD_BITS(WB),
		.FRAC_BITS(FB)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.point    (point_ch),
		.result   (result_ch),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	stim_t  pending_stim[$];
	fold_t  expected_folds[$];

	// Local copy of the register file, updated as the driver writes it.
	logic [mdr_pkg::ITER_W-1:0] cap_now = mdr_pkg::MAX_ITER_RST;
	logic [mdr_pkg::THR_W-1:0]  thr_now = mdr_pkg::NORM_THR_RST;

	bit     calm_now = 1'b0;
	bit     hold_go = 1'b0;
	int     mismatches = 0;
	longint stall_cycles = 0;
	longint wd_limit;

	// Slowest legal gap between two transactions for a given round cap, with margin.
	function automatic longint stall_limit(logic [mdr_pkg::ITER_W-1:0] cap);
		return 4 * (longint'(cap) * ROUND_CYCLES + CLOSE_CYCLES + HOLD_CYCLES + 200);
	endfunction

	// Fold one point: translate, test the norm, invert, until stop or the cap runs out.
	function automatic fold_t fold_point(logic signed [WB-1:0] x_start, logic [WB-2:0] y_start,
		logic [mdr_pkg::ITER_W-1:0] cap, logic [mdr_pkg::THR_W-1:0] thr);
		fold_t                res;
		logic signed [WB-1:0] x;
		logic [WB-2:0]        y;
		logic [FB-1:0]        frac;
		logic [WB-1:0]        ax;
		logic [2*WB-1:0]      nrm;
		logic [2*WB-1:0]      n;
		logic [2*WB-1:0]      qx;
		logic [2*WB-1:0]      qy;
		logic [2*WB-1:0]      sat;
		int unsigned          rounds;
		bit                   stopped;
		x = x_start;
		y = y_start;
		rounds = 0;
		stopped = 1'b0;
		sat = ({{(2*WB-1){1'b0}}, 1'b1} << (WB - 1)) - 1;
		while (rounds < cap) begin
			frac = x[FB-1:0];
			// Round half away from zero: a tie flips to the opposite half.
			if (frac > HALF_FX[FB-1:0])
				x = {{(WB-FB){1'b1}}, frac};
			else if (frac == HALF_FX[FB-1:0])
				x = x[WB-1] ? HALF_FX : -HALF_FX;
			else
				x = {{(WB-FB){1'b0}}, frac};
			ax = x[WB-1] ? WB'(-x) : WB'(x);
			nrm = (2*WB)'(ax) * (2*WB)'(ax) + (2*WB)'(y) * (2*WB)'(y);
			if (nrm >= ((2*WB)'(thr) << FB)) begin
				stopped = 1'b1;
				break;
			end
			// Truncate the norm, lift a zero to one LSB, then saturate both quotients.
			n = nrm >> FB;
			if (n == 0)
				n = 1;
			qx = ((2*WB)'(ax) << FB) / n;
			qy = ((2*WB)'(y) << FB) / n;
			if (qx > sat)
				qx = sat;
			if (qy > sat)
				qy = sat;
			x = (x > 0) ? -$signed(qx[WB-1:0]) : $signed(qx[WB-1:0]);
			y = qy[WB-2:0];
			rounds++;
		end
		res.x = x;
		res.y = y;
		res.rounds = mdr_pkg::ITER_W'(rounds);
		res.cap_hit = !stopped;
		return res;
	endfunction

	task automatic push_point(logic signed [WB-1:0] x, logic [WB-2:0] y, bit calm = 1'b0);
		stim_t s;
		s = '{STIM_POINT, x, y, calm, '0, '0};
		pending_stim.push_back(s);
	endtask

	task automatic push_cfg(logic [mdr_pkg::CFG_IDX_W-1:0] idx,
		logic [mdr_pkg::CFG_DATA_W-1:0] val);
		stim_t s;
		s = '{STIM_CFG, '0, '0, 1'b0, idx, val};
		pending_stim.push_back(s);
	endtask

	task automatic push_ctrl(stim_kind_t kind);
		stim_t s;
		s = '{kind, '0, '0, 1'b0, '0, '0};
		pending_stim.push_back(s);
	endtask

	task automatic push_settings(logic [mdr_pkg::ITER_W-1:0] cap,
		logic [mdr_pkg::THR_W-1:0] thr);
		push_cfg(mdr_pkg::REG_MAX_ITER, mdr_pkg::CFG_DATA_W'(cap));
		push_cfg(mdr_pkg::REG_NORM_THR, mdr_pkg::CFG_DATA_W'(thr));
	endtask

	// Random points: x spread over full range, near zero, on ties and near integers;
	// y spread on a log scale so that small values drive many rounds.
	task automatic push_random(int count, bit calm, bit y_zero_ok);
		logic [63:0]          rx;
		logic [63:0]          ry;
		logic signed [WB-1:0] x;
		logic [WB-2:0]        y;
		for (int i = 0; i < count; i++) begin
			rx = {$urandom, $urandom};
			ry = {$urandom, $urandom};
			case ($urandom_range(3))
				0: x = rx[WB-1:0];
				1: x = {{(WB-28){rx[27]}}, rx[27:0]};
				2: x = {rx[WB-1:FB], HALF_FX[FB-1:0]};
				default: x = {rx[WB-1:FB], 16'h0, rx[7:0]};
			endcase
			y = ry[WB-2:0] >> $urandom_range(WB - 2, 0);
			if (y == 0 && !y_zero_ok)
				y = 1;
			push_point(x, y, calm);
		end
	endtask

	// Free-running clock, 10 ns period.
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Driver: pop the pending queue, offer points, write registers and pause when idle.
	always @(posedge clk or negedge arst_n) begin : drive_points
		stim_t head;
		bit    offer;
		if (!arst_n) begin
			point_ch.valid <= 1'b0;
			point_ch.x_in <= '0;
			point_ch.y_in <= '0;
			cfg_wr_en <= 1'b0;
			cfg_index <= '0;
			cfg_data <= '0;
			hold_go <= 1'b0;
		end else begin
			offer = 1'b0;
			cfg_wr_en <= 1'b0;
			hold_go <= 1'b0;
			// Predict the result of a point at the edge its transaction completes.
			if (point_ch.valid && point_ch.ready)
				expected_folds.push_back(fold_point(point_ch.x_in, point_ch.y_in,
					cap_now, thr_now));
			if (point_ch.valid && !point_ch.ready) begin
				// Hold the offered point until it is taken.
				offer = 1'b1;
			end else if (pending_stim.size() > 0) begin
				head = pending_stim[0];
				case (head.kind)
					STIM_POINT: begin
						if (head.calm || $urandom_range(99) >= 26) begin
							point_ch.x_in <= head.x;
							point_ch.y_in <= head.y;
							calm_now <= head.calm;
							offer = 1'b1;
							void'(pending_stim.pop_front());
						end
					end
					STIM_CFG: begin
						// Write registers only once every result is back.
						if (expected_folds.size() == 0) begin
							cfg_wr_en <= 1'b1;
							cfg_index <= head.reg_idx;
							cfg_data <= head.reg_val;
							if (head.reg_idx == mdr_pkg::REG_MAX_ITER) begin
								cap_now = head.reg_val[mdr_pkg::ITER_W-1:0];
								wd_limit = stall_limit(head.reg_val[mdr_pkg::ITER_W-1:0]);
							end else begin
								thr_now = head.reg_val[mdr_pkg::THR_W-1:0];
							end
							void'(pending_stim.pop_front());
						end
					end
					STIM_DRAIN: begin
						if (expected_folds.size() == 0)
							void'(pending_stim.pop_front());
					end
					default: begin
						hold_go <= 1'b1;
						void'(pending_stim.pop_front());
					end
				endcase
			end
			point_ch.valid <= offer;
		end
	end

	// Receiver: random back-pressure, none during calm stretches, plus one long hold-off.
	always @(posedge clk or negedge arst_n) begin : take_results
		int hold_left;
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			hold_left = 0;
		end else begin
			if (hold_go)
				hold_left = HOLD_CYCLES;
			if (hold_left > 0) begin
				result_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				result_ch.ready <= calm_now || $urandom_range(99) >= 26;
			end
		end
	end

	// Checker: compare each result with the oldest prediction, field by field.
	always @(posedge clk) begin : check_results
		fold_t want;
		fold_t got;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			got = '{result_ch.x_out, result_ch.y_out, result_ch.rounds_used,
				result_ch.cap_reached};
			if (expected_folds.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result, expected none, got %p", $realtime, got);
			end else begin
				want = expected_folds.pop_front();
				if (want != got) begin
					mismatches++;
					if (want.x != got.x)
						$display("%0t: x_out expected %0d, got %0d",
							$realtime, want.x, got.x);
					if (want.y != got.y)
						$display("%0t: y_out expected %0d, got %0d",
							$realtime, want.y, got.y);
					if (want.rounds != got.rounds)
						$display("%0t: rounds_used expected %0d, got %0d",
							$realtime, want.rounds, got.rounds);
					if (want.cap_hit != got.cap_hit)
						$display("%0t: cap_reached expected %0b, got %0b",
							$realtime, want.cap_hit, got.cap_hit);
				end
			end
		end
	end

	// Watchdog: end the run when no transaction happens for too long.
	always @(posedge clk) begin : watchdog
		if (!arst_n || (point_ch.valid && point_ch.ready)
			|| (result_ch.valid && result_ch.ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= wd_limit) begin
			$display("%0t: no transaction for %0d cycles", $realtime, stall_cycles);
			$display("[modular_domain_reducer] ERROR");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin : run_stimulus
		logic [mdr_pkg::ITER_W-1:0] cap;
		logic [mdr_pkg::THR_W-1:0]  thr;
		arst_n = 1'b0;
		wd_limit = stall_limit(mdr_pkg::MAX_ITER_RST);

		// Directed points under the reset settings.
		push_point('0, Y_ONE);
		push_point(HALF_FX, Y_ONE);                   // tie, non-negative: goes to -1/2
		push_point(-HALF_FX, Y_ONE);                  // tie, negative: goes to +1/2
		push_point(7 * HALF_FX, Y_ONE);               // 3.5
		push_point(-5 * HALF_FX, Y_ONE);              // -2.5
		push_point(X_MAX, Y_MAX);
		push_point(X_MIN, Y_ONE);
		push_point('0, Y_ONE >> 1);                   // one inversion
		push_point('0, 47'd1);                        // tiny norm lifted to one LSB
		push_point(ONE_FX >>> 2, 47'd1);
		push_point(48'sd5033165, 47'd3355443);        // 0.3 + 0.2i, several rounds
		push_point(48'sd8220836, 47'd167772);         // 0.49 + 0.01i

		// No round at all: point comes back untranslated with the cap flag.
		push_settings('0, mdr_pkg::NORM_THR_RST);
		push_point(X_MAX, 47'd5);
		push_point(48'sd62075700, '0);

		// Single round: the cap allows at most one inversion.
		push_settings(16'd1, mdr_pkg::NORM_THR_RST);
		push_point(48'sd1677722, 47'd1677722);
		push_point('0, Y_ONE);

		// y = 0 never grows; rounds run to the cap.
		push_settings(16'd3, mdr_pkg::NORM_THR_RST);
		push_point('0, '0);
		push_point(X_MIN, '0);

		// Zero threshold: every point stops at the first check.
		push_settings(16'hFFFF, '0);
		push_point('0, '0);
		push_point(X_MAX, '0);

		// Thresholds beyond the unit circle.
		push_settings(16'd2, THR_TOP);
		push_point('0, Y_ONE);
		push_point(HALF_FX, Y_MAX);
		push_settings(16'd2, THR_TWO);
		push_point('0, Y_ONE);

		// Random part under the reset settings, with a full drain midway.
		push_settings(mdr_pkg::MAX_ITER_RST, mdr_pkg::NORM_THR_RST);
		push_random(225, 1'b0, 1'b0);
		push_ctrl(STIM_DRAIN);
		push_random(225, 1'b0, 1'b0);

		// Small caps and thresholds up to one.
		for (int p = 0; p < 4; p++) begin
			cap = mdr_pkg::ITER_W'($urandom_range(40, 1));
			thr = mdr_pkg::THR_W'($urandom_range(1 << FB, 0));
			push_settings(cap, thr);
			push_random(100, 1'b0, 1'b1);
		end

		// Fast points while the receiver holds off, so the block backs up.
		push_settings(16'hFFFF, '0);
		push_random(60, 1'b0, 1'b1);
		push_ctrl(STIM_HOLD);
		push_random(140, 1'b0, 1'b1);

		// Thresholds above one: most points run out of rounds.
		push_settings(16'd6, THR_TOP);
		push_random(150, 1'b0, 1'b1);
		push_settings(16'd1, THR_TWO);
		push_random(100, 1'b0, 1'b1);

		// Threshold between one and two, first with no idling on either side.
		thr = mdr_pkg::THR_W'($urandom_range(1 << (FB + 1), 1 << FB));
		push_settings(16'd10, thr);
		push_random(150, 1'b1, 1'b1);
		push_random(150, 1'b0, 1'b1);

		push_settings(16'd40, mdr_pkg::NORM_THR_RST);
		push_random(150, 1'b0, 1'b0);

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Wait until every point is taken and every result is back.
		do
			@(posedge clk);
		while (pending_stim.size() != 0 || expected_folds.size() != 0 || point_ch.valid);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mismatches == 0 && expected_folds.size() == 0)
			$display("[modular_domain_reducer] OK");
		else
			$display("[modular_domain_reducer] ERROR");
		$finish;
	end

endmodule
